// ===== hw/rtl/srtn_pkg.sv =====
`timescale 1ns / 1ps

package srtn_pkg;

    // Slot indexes are carried at the width needed for the largest table.
    localparam int PROC_IDX_W = 6;
    localparam int TIME_W     = 32;
    localparam int VAL_W      = 16;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 136;
    localparam int STATUS_W   = 2;
    localparam int PID_W      = 5;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_LOAD_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LOAD_REJ = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RAN      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_IDLE     = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_RESULT
    } state_t;

    // Best candidate seen so far, handed from cell to cell.
    typedef struct packed {
        logic                  found;
        logic [VAL_W-1:0]      rem;
        logic [PROC_IDX_W-1:0] idx;
        logic [VAL_W-1:0]      arr;
        logic [VAL_W-1:0]      bur;
    } best_t;

    // Table update controls broadcast to every cell.
    typedef struct packed {
        logic                  load_en;
        logic [PROC_IDX_W-1:0] load_slot;
        logic [VAL_W-1:0]      arr;
        logic [VAL_W-1:0]      bur;
        logic                  dec_en;
        logic [PROC_IDX_W-1:0] dec_slot;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/srtn_preemptive_scheduler.sv =====
`timescale 1ns / 1ps
// Load word: captured while idle, then the result state registers the result word once the
// output is free. Tick word: captured while idle, then the sweep carries the best candidate
// through MAX_PROCS registered cells before the result state registers the result word.
// One word is in work at a time; a finished result may wait while the next word is taken.
// Reset (aresetn low, synchronous) clears time, counts, remaining times and the output
// valid; arrival and burst entries are left as they are until loaded.
module srtn_preemptive_scheduler import srtn_pkg::*; #(
    parameter int MAX_PROCS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [15:0] arrival_time, [31:16] burst_time
    input  logic [S_DATA_W-1:0] s_tdata,
    // [0] func
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [4:0] process_id, [36:5] tick_time, [37] finished, [69:38] completion_time,
    // [101:70] turnaround_time, [133:102] waiting_time, [134] all_done, [135] zero
    output logic [M_DATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [STATUS_W-1:0] m_tuser
);

    localparam int LC_W  = $clog2(MAX_PROCS + 1);
    localparam int CNT_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                func_reg, func_next;
    logic [VAL_W-1:0]    in_arr_reg, in_arr_next;
    logic [VAL_W-1:0]    in_bur_reg, in_bur_next;
    logic [LC_W-1:0]     loaded_reg, loaded_next;
    logic [LC_W-1:0]     completed_reg, completed_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic [STATUS_W-1:0] m_user_reg, m_user_next;

    cell_ctrl_t          ctrl;
    best_t               chain_w [0:MAX_PROCS];
    best_t               best;
    logic                out_free;
    logic                reject;
    logic                fin;
    logic [TIME_W-1:0]   end_time;
    logic [TIME_W-1:0]   tat;
    logic [TIME_W-1:0]   bur_ext;
    logic [TIME_W-1:0]   wait_t;
    logic [PID_W-1:0]    pid;
    logic [TIME_W-1:0]   tick_out;
    logic                fin_out;
    logic [TIME_W-1:0]   comp_out;
    logic [TIME_W-1:0]   tat_out;
    logic [TIME_W-1:0]   wait_out;

    assign chain_w[0] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_PROCS; g++) begin : g_cell
            srtn_cell #(
                .CELL_IDX(g)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl_i  (ctrl),
                .time_i  (time_reg),
                .best_i  (chain_w[g]),
                .best_o  (chain_w[g+1])
            );
        end
    endgenerate

    assign best = chain_w[MAX_PROCS];

    always_comb begin
        out_free = !m_valid_reg || m_tready;
        reject   = (loaded_reg == LC_W'(MAX_PROCS)) || (in_bur_reg == '0);
        fin      = best.found && (best.rem == VAL_W'(1));
        end_time = (time_reg == TIME_MAX) ? TIME_MAX : time_reg + 1'b1;
        tat      = end_time - {{(TIME_W-VAL_W){1'b0}}, best.arr};
        bur_ext  = {{(TIME_W-VAL_W){1'b0}}, best.bur};
        wait_t   = (tat >= bur_ext) ? (tat - bur_ext) : '0;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        func_next      = func_reg;
        in_arr_next    = in_arr_reg;
        in_bur_next    = in_bur_reg;
        loaded_next    = loaded_reg;
        completed_next = completed_reg;
        time_next      = time_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        s_tready       = (state_reg == ST_IDLE);

        ctrl           = '0;
        ctrl.load_slot = PROC_IDX_W'(loaded_reg);
        ctrl.arr       = in_arr_reg;
        ctrl.bur       = in_bur_reg;
        ctrl.dec_slot  = best.idx;

        pid      = '0;
        tick_out = '0;
        fin_out  = 1'b0;
        comp_out = '0;
        tat_out  = '0;
        wait_out = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next   = s_tuser;
                    in_arr_next = s_tdata[15:0];
                    in_bur_next = s_tdata[31:16];
                    cnt_next    = '0;
                    state_next  = (s_tuser == FUNC_TICK) ? ST_SWEEP : ST_RESULT;
                end
            end
            ST_SWEEP: begin
                // The last cell holds a settled answer once the sweep has crossed every cell.
                if (cnt_reg == CNT_W'(MAX_PROCS - 1)) begin
                    state_next = ST_RESULT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    if (func_reg == FUNC_LOAD) begin
                        if (reject) begin
                            m_user_next = STATUS_LOAD_REJ;
                        end else begin
                            m_user_next  = STATUS_LOAD_OK;
                            ctrl.load_en = 1'b1;
                            loaded_next  = loaded_reg + 1'b1;
                            pid          = PID_W'(7'(loaded_reg) + 7'd1);
                        end
                    end else begin
                        tick_out  = time_reg;
                        time_next = end_time;
                        if (best.found) begin
                            m_user_next = STATUS_RAN;
                            ctrl.dec_en = 1'b1;
                            pid         = PID_W'(7'(best.idx) + 7'd1);
                            if (fin) begin
                                fin_out        = 1'b1;
                                comp_out       = end_time;
                                tat_out        = tat;
                                wait_out       = wait_t;
                                completed_next = completed_reg + 1'b1;
                            end
                        end else begin
                            m_user_next = STATUS_IDLE;
                        end
                    end
                    m_data_next = {1'b0, (completed_next == loaded_next), wait_out, tat_out,
                                   comp_out, fin_out, tick_out, pid};
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            loaded_reg    <= '0;
            completed_reg <= '0;
            time_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            loaded_reg    <= loaded_next;
            completed_reg <= completed_next;
            time_reg      <= time_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        in_arr_reg <= in_arr_next;
        in_bur_reg <= in_bur_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== hw/rtl/srtn_cell.sv =====
`timescale 1ns / 1ps

module srtn_cell import srtn_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_ctrl_t        ctrl_i,
    input  logic [TIME_W-1:0] time_i,
    input  best_t             best_i,
    output best_t             best_o
);

    localparam logic [PROC_IDX_W-1:0] MY_IDX = PROC_IDX_W'(CELL_IDX);

    logic [VAL_W-1:0] arr_reg;
    logic [VAL_W-1:0] bur_reg;
    logic [VAL_W-1:0] rem_reg;
    best_t            best_reg;
    best_t            best_next;
    logic             take;

    // Slots never loaded keep a zero remaining time, so they never compete.
    always_comb begin
        take = (rem_reg != '0) && ({{(TIME_W-VAL_W){1'b0}}, arr_reg} <= time_i)
               && (!best_i.found || (rem_reg < best_i.rem));
        best_next = best_i;
        if (take) begin
            best_next.found = 1'b1;
            best_next.rem   = rem_reg;
            best_next.idx   = MY_IDX;
            best_next.arr   = arr_reg;
            best_next.bur   = bur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        best_reg.rem <= best_next.rem;
        best_reg.idx <= best_next.idx;
        best_reg.arr <= best_next.arr;
        best_reg.bur <= best_next.bur;
        if (ctrl_i.load_en && (ctrl_i.load_slot == MY_IDX)) begin
            arr_reg <= ctrl_i.arr;
            bur_reg <= ctrl_i.bur;
        end
        if (!aresetn) begin
            rem_reg        <= '0;
            best_reg.found <= 1'b0;
        end else begin
            best_reg.found <= best_next.found;
            if (ctrl_i.load_en && (ctrl_i.load_slot == MY_IDX)) begin
                rem_reg <= ctrl_i.bur;
            end else if (ctrl_i.dec_en && (ctrl_i.dec_slot == MY_IDX)) begin
                rem_reg <= rem_reg - 1'b1;
            end
        end
    end

    assign best_o = best_reg;

endmodule

// ===== hw/rtl/srtn_checker.sv =====
`timescale 1ns / 1ps

module srtn_checker import srtn_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0] m_tuser
);

    // A stalled result word holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Rejected loads and idle ticks carry no process and no completion.
    a_no_pid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == STATUS_LOAD_REJ) || (m_tuser == STATUS_IDLE))
        |-> (m_tdata[4:0] == '0) && !m_tdata[37])
        else $error("process id or finish flag on a word without a process");

    // Only a tick that ran a process can finish one, and that process has an id.
    a_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[37] |-> (m_tuser == STATUS_RAN) && (m_tdata[4:0] != '0))
        else $error("finish flag without a running process");

    // Loads report no tick time.
    a_load_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == STATUS_LOAD_OK) || (m_tuser == STATUS_LOAD_REJ))
        |-> (m_tdata[36:5] == '0))
        else $error("tick time on a load word");

endmodule

bind srtn_preemptive_scheduler srtn_checker u_srtn_checker (.*);
